FILE: rtl/evad_pkg.sv
// Shared types and constants for the energy voice activity detector.
`timescale 1ns / 1ps

package evad_pkg;

  localparam int EXTRA_BITS = 24;              // state bits kept below the output LSB
  localparam int STATE_W    = 58;              // energy and noise state width
  localparam int DC_W       = 40;              // biased DC estimate width
  localparam int ENERGY_W   = 34;              // energy with 32 fraction bits
  localparam int SAMPLE_W   = 16;
  localparam int RATIO_W    = 8;
  localparam int MUL_A_W    = 34;              // wide operand of the shared multiplier
  localparam int CFG_DATA_W = 34;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DC_COEFF    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_COEFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_RISE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_RATIO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_RATIO  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_HOLD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END_HOLD    = 3'd7;

  typedef struct packed {
    logic loud;
    logic quiet;
  } level_flags_t;

  typedef struct packed {
    logic voice;
    logic start_p;
    logic end_p;
  } voice_event_t;

endpackage

FILE: rtl/evad_mul.sv
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module evad_mul #(
  parameter int A_W = 34,
  parameter int B_W = 24
) (
  input  logic                 clk,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic [A_W+B_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= {{B_W{1'b0}}, a} * {{A_W{1'b0}}, b};
  end

endmodule

FILE: rtl/evad_decide.sv
// Voice start and end decision with saturating loud and quiet run counters.
`timescale 1ns / 1ps

module evad_decide
  import evad_pkg::*;
#(
  parameter int HOLD_BITS = 16
) (
  input  level_flags_t          flags,
  input  logic                  voice,
  input  logic [HOLD_BITS-1:0]  loud_run,
  input  logic [HOLD_BITS-1:0]  quiet_run,
  input  logic [HOLD_BITS-1:0]  start_hold,
  input  logic [HOLD_BITS-1:0]  end_hold,
  output voice_event_t          evt,
  output logic [HOLD_BITS-1:0]  loud_run_next,
  output logic [HOLD_BITS-1:0]  quiet_run_next
);

  logic [HOLD_BITS-1:0] loud_inc;
  logic [HOLD_BITS-1:0] quiet_inc;

  // saturate at all ones
  assign loud_inc  = (&loud_run)  ? loud_run  : loud_run + 1'b1;
  assign quiet_inc = (&quiet_run) ? quiet_run : quiet_run + 1'b1;

  always_comb begin
    evt            = '{voice: voice, start_p: 1'b0, end_p: 1'b0};
    loud_run_next  = loud_run;
    quiet_run_next = quiet_run;
    if (!voice) begin
      if (flags.loud) begin
        if (loud_inc > start_hold) begin
          evt.voice      = 1'b1;
          evt.start_p    = 1'b1;
          loud_run_next  = '0;
          quiet_run_next = '0;
        end else begin
          loud_run_next = loud_inc;
        end
      end else begin
        loud_run_next = '0;
      end
    end else begin
      if (flags.quiet) begin
        if (quiet_inc > end_hold) begin
          evt.voice      = 1'b0;
          evt.end_p      = 1'b1;
          loud_run_next  = '0;
          quiet_run_next = '0;
        end else begin
          quiet_run_next = quiet_inc;
        end
      end else begin
        quiet_run_next = '0;
      end
    end
  end

endmodule

FILE: rtl/energy_voice_activity_detector.sv
// Energy voice activity detector: sequencer, filter state and output register.
// Each filter step makes two passes of the shared multiplier, high and low partial.
// in_ready is high only when idle, so a new sample waits until the last one is done.
// A finished result waits in the output register while the next sample works.
// Synchronous reset restores default configuration, sets the noise floor to 1.0,
// sets the biased DC estimate to its midpoint and clears energy, voice and counters.
`timescale 1ns / 1ps

module energy_voice_activity_detector
  import evad_pkg::*;
#(
  parameter int COEFF_BITS = 24,
  parameter int HOLD_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMPLE_W-1:0]   sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         voice_active,
  output logic                         start_pulse,
  output logic                         end_pulse,
  output logic signed [SAMPLE_W:0]     dc_removed,
  output logic [ENERGY_W-1:0]          fast_energy,
  output logic [ENERGY_W-1:0]          noise_floor,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int P_W = MUL_A_W + COEFF_BITS;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DC_DIFF = 4'd1;
  localparam logic [3:0] ST_T_HI    = 4'd2;
  localparam logic [3:0] ST_T_LO    = 4'd3;
  localparam logic [3:0] ST_T_SUM   = 4'd4;
  localparam logic [3:0] ST_T_APPLY = 4'd5;
  localparam logic [3:0] ST_Z       = 4'd6;
  localparam logic [3:0] ST_SQ      = 4'd7;
  localparam logic [3:0] ST_EN_DIFF = 4'd8;
  localparam logic [3:0] ST_NS_CMP  = 4'd9;
  localparam logic [3:0] ST_CLAMP   = 4'd10;
  localparam logic [3:0] ST_RATIO_A = 4'd11;
  localparam logic [3:0] ST_RATIO_B = 4'd12;
  localparam logic [3:0] ST_DECIDE  = 4'd13;

  localparam logic [1:0] PH_DC = 2'd0;
  localparam logic [1:0] PH_EN = 2'd1;
  localparam logic [1:0] PH_NS = 2'd2;

  // configuration
  logic [COEFF_BITS-1:0] dc_coeff, energy_coeff, noise_rise_coeff;
  logic [ENERGY_W-1:0]   noise_minimum;
  logic [RATIO_W-1:0]    start_ratio, stop_ratio;
  logic [HOLD_BITS-1:0]  start_hold, end_hold;

  // filter and decision state
  logic [DC_W-1:0]       dcb;
  logic [STATE_W-1:0]    energy, noise;
  logic                  voice;
  logic [HOLD_BITS-1:0]  loud_run, quiet_run;

  // sequencer and working registers
  logic [3:0]            state;
  logic [1:0]            phase;
  logic [SAMPLE_W-1:0]   smp;
  logic [STATE_W-1:0]    diff;
  logic                  neg;
  logic [STATE_W-1:0]    step;
  logic signed [SAMPLE_W:0] z;
  logic [SAMPLE_W-1:0]   mag;
  logic                  loud;

  logic [MUL_A_W-1:0]    mul_a;
  logic [COEFF_BITS-1:0] mul_b;
  logic [P_W-1:0]        prod;

  logic [COEFF_BITS-1:0] coef;
  logic [P_W+31:0]       hi_ext;
  logic [P_W-1:0]        lo_ext;
  logic [STATE_W-1:0]    old_val, new_val;
  logic [DC_W-1:0]       dc_tgt;
  logic [STATE_W-1:0]    sq_tgt;
  logic [STATE_W-1:0]    floor_min;
  logic [ENERGY_W-1:0]   e32, n32;
  logic [P_W-1:0]        e16;
  logic signed [SAMPLE_W:0] z_w;
  logic                  out_free;

  level_flags_t          flags;
  voice_event_t          evt;
  logic [HOLD_BITS-1:0]  loud_run_next, quiet_run_next;

  evad_mul #(
    .A_W (MUL_A_W),
    .B_W (COEFF_BITS)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  evad_decide #(
    .HOLD_BITS (HOLD_BITS)
  ) u_decide (
    .flags          (flags),
    .voice          (voice),
    .loud_run       (loud_run),
    .quiet_run      (quiet_run),
    .start_hold     (start_hold),
    .end_hold       (end_hold),
    .evt            (evt),
    .loud_run_next  (loud_run_next),
    .quiet_run_next (quiet_run_next)
  );

  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign e32       = energy[STATE_W-1:EXTRA_BITS];
  assign n32       = noise[STATE_W-1:EXTRA_BITS];
  assign e16       = P_W'({e32, 4'b0000});
  assign dc_tgt    = {smp, {EXTRA_BITS{1'b0}}};
  assign sq_tgt    = {prod[31:0], 2'b00, {EXTRA_BITS{1'b0}}};
  assign floor_min = {noise_minimum, {EXTRA_BITS{1'b0}}};
  assign z_w       = $signed({1'b0, smp}) - $signed({1'b0, dcb[DC_W-1:EXTRA_BITS]});

  // scaled step: high partial lands above bit 32-COEFF_BITS, low partial is shifted down
  assign hi_ext    = {32'b0, prod} << (32 - COEFF_BITS);
  assign lo_ext    = prod >> COEFF_BITS;

  assign flags.loud  = loud;
  assign flags.quiet = e16 < prod;

  always_comb begin
    case (phase)
      PH_DC:   coef = dc_coeff;
      PH_EN:   coef = energy_coeff;
      default: coef = noise_rise_coeff;
    endcase
  end

  always_comb begin
    case (phase)
      PH_DC:   old_val = STATE_W'(dcb);
      PH_EN:   old_val = energy;
      default: old_val = noise;
    endcase
    new_val = neg ? old_val - step : old_val + step;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_T_HI: begin
        mul_a = MUL_A_W'(diff[STATE_W-1:32]);
        mul_b = coef;
      end
      ST_T_LO: begin
        mul_a = MUL_A_W'(diff[31:0]);
        mul_b = coef;
      end
      ST_SQ: begin
        mul_a = MUL_A_W'(mag);
        mul_b = COEFF_BITS'(mag);
      end
      ST_RATIO_A: begin
        mul_a = n32;
        mul_b = COEFF_BITS'(start_ratio);
      end
      ST_RATIO_B, ST_DECIDE: begin
        mul_a = n32;
        mul_b = COEFF_BITS'(stop_ratio);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_coeff         <= COEFF_BITS'(13176);
      energy_coeff     <= COEFF_BITS'(52707);
      noise_rise_coeff <= COEFF_BITS'(659);
      noise_minimum    <= ENERGY_W'(655360);
      start_ratio      <= RATIO_W'(64);
      stop_ratio       <= RATIO_W'(48);
      start_hold       <= HOLD_BITS'(800);
      end_hold         <= HOLD_BITS'(4000);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DC_COEFF:     dc_coeff         <= cfg_data[COEFF_BITS-1:0];
        REG_ENERGY_COEFF: energy_coeff     <= cfg_data[COEFF_BITS-1:0];
        REG_NOISE_RISE:   noise_rise_coeff <= cfg_data[COEFF_BITS-1:0];
        REG_NOISE_MIN:    noise_minimum    <= cfg_data[ENERGY_W-1:0];
        REG_START_RATIO:  start_ratio      <= cfg_data[RATIO_W-1:0];
        REG_STOP_RATIO:   stop_ratio       <= cfg_data[RATIO_W-1:0];
        REG_START_HOLD:   start_hold       <= cfg_data[HOLD_BITS-1:0];
        REG_END_HOLD:     end_hold         <= cfg_data[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_DC;
      out_valid <= 1'b0;
      dcb       <= {1'b1, {(DC_W-1){1'b0}}};
      energy    <= '0;
      noise     <= STATE_W'(1) << 56;
      voice     <= 1'b0;
      loud_run  <= '0;
      quiet_run <= '0;
    end else begin
      // the decide step loads the next result itself
      if (out_valid && out_ready && state != ST_DECIDE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_DC_DIFF;
          end
        end
        ST_DC_DIFF: begin
          phase <= PH_DC;
          state <= ST_T_HI;
        end
        ST_T_HI:   state <= ST_T_LO;
        ST_T_LO:   state <= ST_T_SUM;
        ST_T_SUM:  state <= ST_T_APPLY;
        ST_T_APPLY: begin
          case (phase)
            PH_DC: begin
              dcb   <= new_val[DC_W-1:0];
              state <= ST_Z;
            end
            PH_EN: begin
              energy <= new_val;
              state  <= ST_NS_CMP;
            end
            default: begin
              noise <= new_val;
              state <= ST_CLAMP;
            end
          endcase
        end
        ST_Z:  state <= ST_SQ;
        ST_SQ: state <= ST_EN_DIFF;
        ST_EN_DIFF: begin
          phase <= PH_EN;
          state <= ST_T_HI;
        end
        ST_NS_CMP: begin
          if (energy < noise) begin
            noise <= energy;
            state <= ST_CLAMP;
          end else begin
            phase <= PH_NS;
            state <= ST_T_HI;
          end
        end
        ST_CLAMP: begin
          if (noise < floor_min) begin
            noise <= floor_min;
          end
          state <= ST_RATIO_A;
        end
        ST_RATIO_A: state <= ST_RATIO_B;
        ST_RATIO_B: state <= ST_DECIDE;
        ST_DECIDE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            voice     <= evt.voice;
            loud_run  <= loud_run_next;
            quiet_run <= quiet_run_next;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        smp <= sample ^ 16'h8000;
      end
      ST_DC_DIFF: begin
        if (dc_tgt >= dcb) begin
          diff <= STATE_W'(dc_tgt - dcb);
          neg  <= 1'b0;
        end else begin
          diff <= STATE_W'(dcb - dc_tgt);
          neg  <= 1'b1;
        end
      end
      ST_T_LO: begin
        step <= hi_ext[STATE_W-1:0];
      end
      ST_T_SUM: begin
        step <= step + STATE_W'(lo_ext);
      end
      ST_Z: begin
        z   <= z_w;
        mag <= z_w[SAMPLE_W] ? (-z_w[SAMPLE_W-1:0]) : z_w[SAMPLE_W-1:0];
      end
      ST_EN_DIFF: begin
        if (sq_tgt >= energy) begin
          diff <= sq_tgt - energy;
          neg  <= 1'b0;
        end else begin
          diff <= energy - sq_tgt;
          neg  <= 1'b1;
        end
      end
      ST_NS_CMP: begin
        diff <= energy - noise;
        neg  <= 1'b0;
      end
      ST_RATIO_B: begin
        loud <= e16 > prod;
      end
      ST_DECIDE: begin
        if (out_free) begin
          voice_active <= evt.voice;
          start_pulse  <= evt.start_p;
          end_pulse    <= evt.end_p;
          dc_removed   <= z;
          fast_energy  <= e32;
          noise_floor  <= n32;
        end
      end
      default: ;
    endcase
  end

endmodule
